FILE: rtl/nsr_pkg.sv
`default_nettype none
package nsr_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int A_W        = DATA_WIDTH - 1;
    localparam int NUM_W      = A_W + FRAC_BITS;
    localparam int X_W        = NUM_W + 1;
    localparam int CNT_W      = $clog2(NUM_W + 1);
    localparam int ROOT_W     = 24;
    localparam int TOL_W      = 16;
    localparam int ITER_W     = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [ROOT_W-1:0] ROOT_MAX     = {ROOT_W{1'b1}};
    localparam logic [TOL_W-1:0]  TOL_RESET    = TOL_W'(1);
    localparam logic [ITER_W-1:0] ITER_RESET   = ITER_W'(40);

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIM  = 1'b1;

    typedef enum logic [1:0] {
        ST_CONV  = 2'd0,
        ST_NEG   = 2'd1,
        ST_LIMIT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    typedef struct packed {
        logic    load;
        logic    div_step;
        logic    update;
        logic    emit;
        logic    zero_root;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic op_neg;
        logic op_zero;
        logic div_last;
        logic converged;
    } t_stat;

endpackage
`default_nettype wire

FILE: rtl/nsr_ctrl.sv
`default_nettype none
module nsr_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [nsr_pkg::ITER_W-1:0]     i_iter_limit,
    input  wire nsr_pkg::t_stat                 i_stat,
    output nsr_pkg::t_cmd                       o_cmd,
    output logic                                o_busy
);

    nsr_pkg::t_state                 r_state, n_state;
    logic [nsr_pkg::ITER_W-1:0]      r_steps, n_steps;
    logic [nsr_pkg::ITER_W:0]        limit_eff;
    logic [nsr_pkg::ITER_W:0]        steps_inc;
    logic                            last_step;

    assign limit_eff = (i_iter_limit == '0) ? (nsr_pkg::ITER_W+1)'(1)
                                            : {1'b0, i_iter_limit};
    assign steps_inc = {1'b0, r_steps} + (nsr_pkg::ITER_W+1)'(1);
    assign last_step = steps_inc >= limit_eff;
    assign o_busy    = (r_state != nsr_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        n_steps = r_steps;
        o_cmd   = '0;
        case (r_state)
            nsr_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_stat.op_neg) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.zero_root = 1'b1;
                        o_cmd.status    = nsr_pkg::ST_NEG;
                    end else if (i_stat.op_zero) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.zero_root = 1'b1;
                        o_cmd.status    = nsr_pkg::ST_CONV;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_steps    = '0;
                        n_state    = nsr_pkg::S_DIV;
                    end
                end
            end
            nsr_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = nsr_pkg::S_UPD;
                end
            end
            nsr_pkg::S_UPD: begin
                o_cmd.update = 1'b1;
                n_steps      = steps_inc[nsr_pkg::ITER_W-1:0];
                if (i_stat.converged) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = nsr_pkg::ST_CONV;
                    n_state      = nsr_pkg::S_IDLE;
                end else if (last_step) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = nsr_pkg::ST_LIMIT;
                    n_state      = nsr_pkg::S_IDLE;
                end else begin
                    n_state = nsr_pkg::S_DIV;
                end
            end
            default: begin
                n_state = nsr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nsr_pkg::S_IDLE;
            r_steps <= '0;
        end else begin
            r_state <= n_state;
            r_steps <= n_steps;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/nsr_dp.sv
`default_nettype none
module nsr_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic signed [nsr_pkg::DATA_WIDTH-1:0] i_operand,
    input  wire logic [nsr_pkg::TOL_W-1:0]         i_tolerance,
    input  wire nsr_pkg::t_cmd                     i_cmd,
    output nsr_pkg::t_stat                         o_stat,
    output logic                                   o_valid,
    output logic [nsr_pkg::ROOT_W-1:0]             o_root,
    output logic [1:0]                             o_status
);

    logic [nsr_pkg::A_W-1:0]    r_a;
    logic [nsr_pkg::X_W-1:0]    r_x, n_x;
    logic [nsr_pkg::X_W-1:0]    r_rem;
    logic [nsr_pkg::NUM_W-1:0]  r_num;
    logic [nsr_pkg::NUM_W-1:0]  r_quo;
    logic [nsr_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_valid;
    logic [nsr_pkg::ROOT_W-1:0] r_root;
    nsr_pkg::t_status           r_status;

    logic [nsr_pkg::A_W-1:0]    load_a;
    logic [nsr_pkg::X_W:0]      trial;
    logic [nsr_pkg::X_W:0]      trial_sub;
    logic                       q_bit;
    logic [nsr_pkg::X_W:0]      sum;
    logic [nsr_pkg::X_W-1:0]    delta;
    logic [nsr_pkg::ROOT_W-1:0] root_sat;

    assign load_a = i_cmd.load ? i_operand[nsr_pkg::A_W-1:0] : r_a;

    // restoring divide, one quotient bit per cycle
    assign trial     = {r_rem, r_num[nsr_pkg::NUM_W-1]};
    assign trial_sub = trial - {1'b0, r_x};
    assign q_bit     = ~trial_sub[nsr_pkg::X_W];

    // x' = (x + q) / 2
    assign sum   = {1'b0, r_x} + (nsr_pkg::X_W+1)'(r_quo);
    assign n_x   = sum[nsr_pkg::X_W:1];
    assign delta = (n_x >= r_x) ? (n_x - r_x) : (r_x - n_x);

    assign root_sat = (n_x > nsr_pkg::X_W'(nsr_pkg::ROOT_MAX)) ? nsr_pkg::ROOT_MAX
                                                              : n_x[nsr_pkg::ROOT_W-1:0];

    assign o_stat.op_neg    = i_operand[nsr_pkg::DATA_WIDTH-1];
    assign o_stat.op_zero   = (i_operand == '0);
    assign o_stat.div_last  = (r_cnt == nsr_pkg::CNT_W'(1));
    assign o_stat.converged = (delta < nsr_pkg::X_W'(i_tolerance));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= i_operand[nsr_pkg::A_W-1:0];
            r_x <= nsr_pkg::X_W'(i_operand[nsr_pkg::A_W-1:0]);
        end else if (i_cmd.update) begin
            r_x <= n_x;
        end
        if (i_cmd.load || i_cmd.update) begin
            r_rem <= '0;
            r_num <= nsr_pkg::NUM_W'(load_a) << nsr_pkg::FRAC_BITS;
            r_quo <= '0;
            r_cnt <= nsr_pkg::CNT_W'(nsr_pkg::NUM_W);
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? trial_sub[nsr_pkg::X_W-1:0] : trial[nsr_pkg::X_W-1:0];
            r_num <= r_num << 1;
            r_quo <= {r_quo[nsr_pkg::NUM_W-2:0], q_bit};
            r_cnt <= r_cnt - nsr_pkg::CNT_W'(1);
        end
        if (i_cmd.emit) begin
            r_root   <= i_cmd.zero_root ? '0 : root_sat;
            r_status <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    assign o_valid  = r_valid;
    assign o_root   = r_root;
    assign o_status = r_status;

endmodule
`default_nettype wire

FILE: rtl/newton_square_root_unit.sv
// Negative or zero operand: the result comes out in the cycle after start.
// Otherwise n Newton steps, 1 <= n <= max(iteration_limit, 1), each a bit-serial
// divide (S_DIV) followed by an update (S_UPD), come before the result.
// Throughput: one word at a time; busy stays high until the result is out.
// Each result strobes o_valid for one cycle; the receiver cannot stall.
// Reset (synchronous, active low) returns to idle and restores config defaults.
`default_nettype none
module newton_square_root_unit (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    output logic                                       o_busy,
    input  wire logic signed [nsr_pkg::DATA_WIDTH-1:0] i_operand,
    input  wire logic                                  i_cfg_we,
    input  wire logic [nsr_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [nsr_pkg::TOL_W-1:0]             i_cfg_wdata,
    output logic                                       o_valid,
    output logic [nsr_pkg::ROOT_W-1:0]                 o_root,
    output logic [1:0]                                 o_status
);

    logic [nsr_pkg::TOL_W-1:0]  r_tolerance;
    logic [nsr_pkg::ITER_W-1:0] r_iter_limit;
    nsr_pkg::t_cmd              cmd;
    nsr_pkg::t_stat             stat;
    logic                       start_acc;

    assign start_acc = i_start & ~o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance  <= nsr_pkg::TOL_RESET;
            r_iter_limit <= nsr_pkg::ITER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nsr_pkg::CFG_TOLERANCE: begin
                    r_tolerance <= i_cfg_wdata;
                end
                nsr_pkg::CFG_ITER_LIM: begin
                    r_iter_limit <= i_cfg_wdata[nsr_pkg::ITER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    nsr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start_acc),
        .i_iter_limit (r_iter_limit),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_busy       (o_busy)
    );

    nsr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_operand   (i_operand),
        .i_tolerance (r_tolerance),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .o_root      (o_root),
        .o_status    (o_status)
    );

endmodule
`default_nettype wire

FILE: rtl/nsr_chk.sv
`default_nettype none
module nsr_chk (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic                                  o_busy,
    input  wire logic signed [nsr_pkg::DATA_WIDTH-1:0] i_operand,
    input  wire logic                                  o_valid,
    input  wire logic [nsr_pkg::ROOT_W-1:0]            o_root,
    input  wire logic [1:0]                            o_status
);

    logic acc;
    assign acc = i_start & ~o_busy;

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == nsr_pkg::ST_CONV || o_status == nsr_pkg::ST_NEG ||
                     o_status == nsr_pkg::ST_LIMIT))
        else $error("bad status code");

    a_neg_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == nsr_pkg::ST_NEG) |-> (o_root == '0))
        else $error("negative word with nonzero root");

    a_neg_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_operand[nsr_pkg::DATA_WIDTH-1]) |=>
            (o_valid && o_status == nsr_pkg::ST_NEG && !o_busy))
        else $error("negative word not answered next cycle");

    a_zero_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_operand == '0) |=>
            (o_valid && o_status == nsr_pkg::ST_CONV && o_root == '0))
        else $error("zero word not answered next cycle");

    a_pos_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_operand[nsr_pkg::DATA_WIDTH-1] && i_operand != '0) |=>
            (o_busy && !o_valid))
        else $error("positive word did not start iteration");

endmodule

bind newton_square_root_unit nsr_chk u_nsr_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_start   (i_start),
    .o_busy    (o_busy),
    .i_operand (i_operand),
    .o_valid   (o_valid),
    .o_root    (o_root),
    .o_status  (o_status)
);
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps
module testbench;
    import nsr_pkg::*;

    localparam int N_DIRECTED  = 23;
    localparam int N_PHASES    = 9;
    localparam int WORD_BOUND  = 500;
    localparam int STEP_CYCLES = 48;
    localparam int GAP_MAX     = 4000;
    localparam int WORST_WORD  = 2 + STEP_CYCLES * 128 + GAP_MAX;
    localparam int CYCLE_LIMIT = 3 * WORST_WORD * WORD_BOUND;
    localparam int DRAIN_CYCLES = 2 * STEP_CYCLES;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        t_status           status;
    } t_root_word;

    typedef struct packed {
        logic [TOL_W-1:0]      tol;
        logic [ITER_W-1:0]     lim;
        logic [DATA_WIDTH-1:0] op;
        logic                  typed;
        logic [ROOT_W-1:0]     root;
        t_status               status;
    } t_dir_row;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [DATA_WIDTH-1:0] operand;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [TOL_W-1:0]      cfg_wdata;
    logic                  res_valid;
    logic [ROOT_W-1:0]     res_root;
    logic [1:0]            res_status;

    // block's register copies
    logic [TOL_W-1:0]  tol_cfg = TOL_RESET;
    logic [ITER_W-1:0] lim_cfg = ITER_RESET;

    t_root_word pending_roots [$];
    t_dir_row   dir_rows [N_DIRECTED];
    int         phase_tol [N_PHASES];
    int         phase_lim [N_PHASES];
    int         phase_len [N_PHASES];

    int mismatches = 0;
    int cycle_count = 0;
    int n_words = 0;
    int n_settings = 1;
    int n_conv = 0;
    int n_neg = 0;
    int n_capped = 0;
    int n_sat = 0;

    newton_square_root_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_operand   (operand),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .o_valid     (res_valid),
        .o_root      (res_root),
        .o_status    (res_status)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL newton_square_root_unit");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic t_root_word predict_root(input logic [DATA_WIDTH-1:0] op);
        logic [63:0] a, x, nx, q, dif;
        logic [64:0] s;
        int unsigned limit_n, steps;
        t_root_word w;
        a = 64'(op);
        w.root = '0;
        w.status = ST_CONV;
        if (op[DATA_WIDTH-1]) begin
            w.status = ST_NEG;
            return w;
        end
        if (a == 0)
            return w;
        limit_n = (lim_cfg == 0) ? 1 : int'(lim_cfg);
        x = a;
        nx = '0;
        w.status = ST_LIMIT;
        for (steps = 0; steps < limit_n; steps++) begin
            q = (x == 0) ? '1 : (a << FRAC_BITS) / x;
            s = {1'b0, x} + {1'b0, q};
            nx = s[64:1];
            dif = (nx >= x) ? nx - x : x - nx;
            if (dif < 64'(tol_cfg)) begin
                w.status = ST_CONV;
                break;
            end
            x = nx;
        end
        w.root = (nx > 64'(ROOT_MAX)) ? ROOT_MAX : nx[ROOT_W-1:0];
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 60);
        return $urandom_range(200, GAP_MAX);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_operand();
        int r;
        int unsigned n;
        r = $urandom_range(0, 99);
        if (r < 25) return $urandom;
        if (r < 45) return $urandom >> $urandom_range(1, 31);
        if (r < 58) begin
            n = $urandom_range(1, 181);
            return (n * n) << FRAC_BITS;
        end
        if (r < 68) return 32'h7FFF_FFFF - $urandom_range(0, 32'hFFFF);
        if (r < 78) return $urandom_range(1, 16);
        if (r < 86) return 32'h8000_0000 | $urandom;
        if (r < 90) return '0;
        return $urandom & 32'h7FFF_FFFF;
    endfunction

    // result checker
    always @(posedge clk) begin
        t_root_word want;
        if (rst_n && res_valid) begin
            if (pending_roots.size() == 0) begin
                report_mismatch($sformatf("word with nothing pending: root %h status %0d",
                                          res_root, res_status));
            end else begin
                want = pending_roots.pop_front();
                if (res_root !== want.root)
                    report_mismatch($sformatf("root %h, expected %h", res_root, want.root));
                if (res_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              res_status, want.status));
            end
        end
    end

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_roots.size() != 0)
            @(negedge clk);
    endtask

    task automatic program_regs(input logic [TOL_W-1:0] tol, input logic [ITER_W-1:0] lim);
        logic [8:0] junk;
        junk = 9'($urandom);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_TOLERANCE;
        cfg_wdata <= tol;
        @(negedge clk);
        cfg_idx <= CFG_ITER_LIM;
        cfg_wdata <= {junk, lim};
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_wdata <= 16'($urandom);
        tol_cfg = tol;
        lim_cfg = lim;
        n_settings++;
    endtask

    task automatic send_word(input logic [DATA_WIDTH-1:0] op, input logic typed,
                             input t_root_word typed_val);
        int gap;
        t_root_word want;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge clk);
            start <= 1'b0;
            operand <= $urandom;
        end
        @(negedge clk);
        start <= 1'b1;
        operand <= op;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        want = typed ? typed_val : predict_root(op);
        pending_roots.push_back(want);
        n_words++;
        case (want.status)
            ST_CONV:  n_conv++;
            ST_NEG:   n_neg++;
            default: begin
                n_capped++;
                if (want.root == ROOT_MAX)
                    n_sat++;
            end
        endcase
    endtask

    initial begin
        t_root_word tv;
        rst_n = 1'b0;
        start = 1'b0;
        operand = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_wdata = '0;

        dir_rows[0]  = '{16'd1, 7'd40, 32'h0000_0000, 1'b1, 24'h0, ST_CONV};
        dir_rows[1]  = '{16'd1, 7'd40, 32'h8000_0000, 1'b1, 24'h0, ST_NEG};
        dir_rows[2]  = '{16'd1, 7'd40, 32'hFFFF_FFFF, 1'b1, 24'h0, ST_NEG};
        dir_rows[3]  = '{16'd1, 7'd40, 32'hAAAA_AAAA, 1'b1, 24'h0, ST_NEG};
        dir_rows[4]  = '{16'd1, 7'd40, 32'h0001_0000, 1'b1, 24'h01_0000, ST_CONV};
        dir_rows[5]  = '{16'd1, 7'd40, 32'h0000_0001, 1'b0, 24'h0, ST_CONV};
        dir_rows[6]  = '{16'd1, 7'd40, 32'h7FFF_FFFF, 1'b0, 24'h0, ST_CONV};
        dir_rows[7]  = '{16'd1, 7'd40, 32'h0004_0000, 1'b0, 24'h0, ST_CONV};
        dir_rows[8]  = '{16'd1, 7'd40, 32'h0002_0000, 1'b0, 24'h0, ST_CONV};
        dir_rows[9]  = '{16'd1, 7'd40, 32'h0000_8000, 1'b0, 24'h0, ST_CONV};
        dir_rows[10] = '{16'd1, 7'd40, 32'h5555_5555, 1'b0, 24'h0, ST_CONV};
        dir_rows[11] = '{16'd1, 7'd40, 32'h0000_0002, 1'b0, 24'h0, ST_CONV};
        dir_rows[12] = '{16'd1, 7'd40, 32'h7FFF_0000, 1'b0, 24'h0, ST_CONV};
        // zero tolerance never settles
        dir_rows[13] = '{16'd0, 7'd5, 32'h0001_0000, 1'b1, 24'h01_0000, ST_LIMIT};
        dir_rows[14] = '{16'd0, 7'd5, 32'h0009_0000, 1'b0, 24'h0, ST_CONV};
        // zero limit acts as one step; large first step saturates
        dir_rows[15] = '{16'd1, 7'd0, 32'h7FFF_FFFF, 1'b1, 24'hFF_FFFF, ST_LIMIT};
        dir_rows[16] = '{16'd1, 7'd0, 32'h0001_0000, 1'b1, 24'h01_0000, ST_CONV};
        dir_rows[17] = '{16'd1, 7'd0, 32'h0000_0000, 1'b1, 24'h0, ST_CONV};
        dir_rows[18] = '{16'hFFFF, 7'd1, 32'h0064_0000, 1'b0, 24'h0, ST_CONV};
        dir_rows[19] = '{16'hFFFF, 7'd127, 32'h7FFF_FFFF, 1'b0, 24'h0, ST_CONV};
        dir_rows[20] = '{16'd1, 7'd64, 32'h1234_5678, 1'b0, 24'h0, ST_CONV};
        dir_rows[21] = '{16'd1, 7'd64, 32'h0000_0003, 1'b0, 24'h0, ST_CONV};
        dir_rows[22] = '{16'd1, 7'd64, 32'h8000_0001, 1'b1, 24'h0, ST_NEG};

        phase_tol = '{1, 0, 65535, 16, 3, 1, $urandom_range(2, 300), 256, 1};
        phase_lim = '{64, 5, 40, 3, 0, 127, $urandom_range(2, 30), 20, 40};
        phase_len = '{80, 30, 50, 50, 40, 10, 60, 60, 60};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (dir_rows[i].tol != tol_cfg || dir_rows[i].lim != lim_cfg)
                program_regs(dir_rows[i].tol, dir_rows[i].lim);
            tv.root = dir_rows[i].root;
            tv.status = dir_rows[i].status;
            send_word(dir_rows[i].op, dir_rows[i].typed, tv);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            program_regs(TOL_W'(phase_tol[p]), ITER_W'(phase_lim[p]));
            for (int k = 0; k < phase_len[p]; k++)
                send_word(pick_operand(), 1'b0, tv);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words over %0d register settings in %0d cycles.",
                 n_words, n_settings, cycle_count);
        $display("Outcomes: %0d converged, %0d negative, %0d step cap (%0d saturated).",
                 n_conv, n_neg, n_capped, n_sat);
        if (mismatches == 0) begin
            $display("PASS newton_square_root_unit");
        end else begin
            $display("FAIL newton_square_root_unit");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/nsr_pkg.sv
rtl/nsr_ctrl.sv
rtl/nsr_dp.sv
rtl/newton_square_root_unit.sv
rtl/nsr_chk.sv
bench/testbench.sv
